// ----- rtl/halton_radical_inverse_macros.svh -----
// Assertion macros shared by the halton_radical_inverse RTL.
`ifndef HALTON_RADICAL_INVERSE_MACROS_SVH
`define HALTON_RADICAL_INVERSE_MACROS_SVH

`ifndef ASSERT_OFF
// Implication checked at every rising edge outside reset.
`define HRI_ASSERT_IMPLY(lbl, clk, rstn, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!(rstn)) (ante) |-> (cons)) \
        else $error(msg);
// Condition that must never be seen outside reset.
`define HRI_ASSERT_NEVER(lbl, clk, rstn, cond, msg) \
    lbl: assert property (@(posedge clk) disable iff (!(rstn)) !(cond)) \
        else $error(msg);
`else
`define HRI_ASSERT_IMPLY(lbl, clk, rstn, ante, cons, msg)
`define HRI_ASSERT_NEVER(lbl, clk, rstn, cond, msg)
`endif

`endif

// ----- rtl/hri_pkg.sv -----
// Shared types and constants for the radical inverse block.
package hri_pkg;

    localparam int SAMPLE_W        = 32;   // sample_index field width
    localparam int RADIX_W         = 16;   // radix field width
    localparam int FRAC_W          = 32;   // fraction field width
    localparam int INDEX_BITS_DEF  = 32;
    localparam int FRAC_BITS_DEF   = 32;
    localparam logic [RADIX_W-1:0] RADIX_MIN = RADIX_W'(2);

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_CHECK,
        ST_DIV_IDX,
        ST_DIV_W,
        ST_MUL,
        ST_ACC,
        ST_DONE
    } state_t;

    typedef struct packed {
        logic busy;
        logic done;   // one-cycle pulse, quotient/remainder valid
    } div_stat_t;

endpackage

// ----- rtl/halton_radical_inverse.sv -----
// Radical inverse (Halton / van der Corput) of an index in a given base.
//
// Each request carries a sample index and a radix; the block mirrors the
// index's base-radix digits about the radix point and returns the value as an
// unsigned Q0.32 fraction. Fixed point throughout: the digit weight starts at
// floor(2^FRAC_BITS / radix) and is divided by the radix (truncating) for each
// further digit; weight*digit is added into the accumulator until the index
// runs out of digits. Radix 0 or 1 returns fraction 0 with bad_base set; index
// 0 returns 0. Only the low INDEX_BITS bits of sample_index are used.
// Flow: one request at a time. Every digit costs two passes through the one
// shared bit-serial divider (index / radix, then weight / radix), of width
// DW = max(INDEX_BITS, FRAC_BITS), plus a multiply state and an accumulate
// state. The result is registered for m_tvalid once the index has run out
// of digits (the digit loop is skipped for index 0 or a bad radix), and
// s_tready comes back in that same cycle; until then no new request is
// taken. With the default 32/32 setup an index has up to 32 digits at
// radix 2.
// The finished result sits in an output register, so the next request is
// taken while the result still waits for m_tready.
`include "halton_radical_inverse_macros.svh"

module halton_radical_inverse #(
    parameter int INDEX_BITS = hri_pkg::INDEX_BITS_DEF,  // 8..64
    parameter int FRAC_BITS  = hri_pkg::FRAC_BITS_DEF    // 16..64
) (
    input  logic        aclk,
    input  logic        aresetn,
    // request channel
    input  logic        s_tvalid,
    output logic        s_tready,
    input  logic [47:0] s_tdata,   // [31:0] sample_index, [47:32] radix
    // result channel
    output logic        m_tvalid,
    input  logic        m_tready,
    output logic [31:0] m_tdata,   // [31:0] fraction
    output logic [0:0]  m_tuser    // [0] bad_base
);

    localparam int RW     = hri_pkg::RADIX_W;
    localparam int SW     = hri_pkg::SAMPLE_W;
    localparam int OW     = hri_pkg::FRAC_W;
    // divider width covers both the index and the weight
    localparam int DW     = (INDEX_BITS > FRAC_BITS) ? INDEX_BITS : FRAC_BITS;
    localparam int IDX_XW = (INDEX_BITS > SW) ? INDEX_BITS : SW;
    localparam int FRC_XW = (FRAC_BITS > OW) ? FRAC_BITS : OW;

    hri_pkg::state_t state_reg, state_next;

    logic [INDEX_BITS-1:0]   idx_reg, idx_next;
    logic [RW-1:0]           radix_reg, radix_next;
    logic [FRAC_BITS-1:0]    w_reg, w_next;
    logic [FRAC_BITS-1:0]    acc_reg, acc_next;
    logic [FRAC_BITS-1:0]    prod_reg, prod_next;
    logic [RW-1:0]           digit_reg, digit_next;
    logic                    first_reg, first_next;
    logic                    out_valid_reg, out_valid_next;
    logic [OW-1:0]           out_frac_reg, out_frac_next;
    logic                    out_bad_reg, out_bad_next;

    logic [IDX_XW-1:0]       idx_in;
    logic [FRC_XW-1:0]       acc_ext;
    logic [FRAC_BITS+RW-1:0] prod_full;
    logic                    radix_bad;
    logic                    first_carry;

    logic                    div_start;
    logic [DW-1:0]           div_dividend;
    logic [DW-1:0]           div_quo;
    logic [RW-1:0]           div_rem;
    hri_pkg::div_stat_t      div_stat;

    hri_div #(
        .WIDTH (DW)
    ) u_div (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .start     (div_start),
        .dividend  (div_dividend),
        .divisor   (radix_reg),
        .quotient  (div_quo),
        .remainder (div_rem),
        .stat      (div_stat)
    );

    assign idx_in    = IDX_XW'(s_tdata[SW-1:0]);
    assign acc_ext   = FRC_XW'(acc_reg);
    assign prod_full = w_reg * digit_reg;
    assign radix_bad = (radix_reg < hri_pkg::RADIX_MIN);
    // floor(2^F/b) from floor((2^F-1)/b): bump when remainder is b-1
    assign first_carry = first_reg && (div_rem == RW'(radix_reg - RW'(1)));

    always_comb begin
        state_next     = state_reg;
        idx_next       = idx_reg;
        radix_next     = radix_reg;
        w_next         = w_reg;
        acc_next       = acc_reg;
        prod_next      = prod_reg;
        digit_next     = digit_reg;
        first_next     = first_reg;
        out_valid_next = out_valid_reg && !m_tready;
        out_frac_next  = out_frac_reg;
        out_bad_next   = out_bad_reg;
        div_start      = 1'b0;
        div_dividend   = DW'(idx_reg);
        s_tready       = 1'b0;

        unique case (state_reg)
            hri_pkg::ST_IDLE: begin
                s_tready = 1'b1;
                if (s_tvalid) begin
                    idx_next   = idx_in[INDEX_BITS-1:0];
                    radix_next = s_tdata[SW+RW-1:SW];
                    acc_next   = '0;
                    first_next = 1'b1;
                    state_next = hri_pkg::ST_CHECK;
                end
            end
            hri_pkg::ST_CHECK: begin
                if (radix_bad || (idx_reg == '0)) begin
                    state_next = hri_pkg::ST_DONE;
                end else begin
                    div_start  = 1'b1;
                    state_next = hri_pkg::ST_DIV_IDX;
                end
            end
            hri_pkg::ST_DIV_IDX: begin
                if (div_stat.done) begin
                    digit_next   = div_rem;
                    idx_next     = div_quo[INDEX_BITS-1:0];
                    div_start    = 1'b1;
                    div_dividend = first_reg ? DW'({FRAC_BITS{1'b1}}) : DW'(w_reg);
                    state_next   = hri_pkg::ST_DIV_W;
                end
            end
            hri_pkg::ST_DIV_W: begin
                if (div_stat.done) begin
                    w_next     = div_quo[FRAC_BITS-1:0] + FRAC_BITS'(first_carry);
                    first_next = 1'b0;
                    state_next = hri_pkg::ST_MUL;
                end
            end
            hri_pkg::ST_MUL: begin
                prod_next  = prod_full[FRAC_BITS-1:0];
                state_next = hri_pkg::ST_ACC;
            end
            hri_pkg::ST_ACC: begin
                acc_next = acc_reg + prod_reg;
                if (idx_reg == '0) begin
                    state_next = hri_pkg::ST_DONE;
                end else begin
                    div_start  = 1'b1;
                    state_next = hri_pkg::ST_DIV_IDX;
                end
            end
            hri_pkg::ST_DONE: begin
                // wait for the output register to drain
                if (!out_valid_reg || m_tready) begin
                    out_valid_next = 1'b1;
                    out_frac_next  = acc_ext[OW-1:0];
                    out_bad_next   = radix_bad;
                    state_next     = hri_pkg::ST_IDLE;
                end
            end
            default: begin
                state_next = hri_pkg::ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg     <= hri_pkg::ST_IDLE;
            out_valid_reg <= 1'b0;
        end else begin
            state_reg     <= state_next;
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge aclk) begin
        idx_reg      <= idx_next;
        radix_reg    <= radix_next;
        w_reg        <= w_next;
        acc_reg      <= acc_next;
        prod_reg     <= prod_next;
        digit_reg    <= digit_next;
        first_reg    <= first_next;
        out_frac_reg <= out_frac_next;
        out_bad_reg  <= out_bad_next;
    end

    assign m_tvalid   = out_valid_reg;
    assign m_tdata    = out_frac_reg;
    assign m_tuser[0] = out_bad_reg;

    // bad radix must always come out with a zero fraction
    `HRI_ASSERT_IMPLY(a_bad_zero, aclk, aresetn, m_tvalid && m_tuser[0], m_tdata == '0,
        "bad_base result with nonzero fraction")
    // divider only finishes while the sequencer is waiting on it
    `HRI_ASSERT_IMPLY(a_done_state, aclk, aresetn, div_stat.done,
        (state_reg == hri_pkg::ST_DIV_IDX) || (state_reg == hri_pkg::ST_DIV_W),
        "divider finished outside a divide state")
    // no new request while the divider still works on the previous one
    `HRI_ASSERT_NEVER(a_idle_busy, aclk, aresetn, s_tready && div_stat.busy,
        "request accepted with divider busy")
    // a divide is never restarted while running
    `HRI_ASSERT_NEVER(a_restart, aclk, aresetn, div_start && div_stat.busy,
        "divider restarted while busy")

endmodule

// ----- rtl/hri_div.sv -----
// Shared restoring divider, one quotient bit per cycle, 16-bit divisor.
module hri_div #(
    parameter int WIDTH = hri_pkg::INDEX_BITS_DEF
) (
    input  logic                        aclk,
    input  logic                        aresetn,
    input  logic                        start,
    input  logic [WIDTH-1:0]            dividend,
    input  logic [hri_pkg::RADIX_W-1:0] divisor,
    output logic [WIDTH-1:0]            quotient,
    output logic [hri_pkg::RADIX_W-1:0] remainder,
    output hri_pkg::div_stat_t          stat
);

    localparam int RW    = hri_pkg::RADIX_W;
    localparam int CNT_W = $clog2(WIDTH);

    logic [WIDTH-1:0] quo_reg, quo_next;
    logic [RW-1:0]    rem_reg, rem_next;
    logic [CNT_W-1:0] cnt_reg, cnt_next;
    logic             busy_reg, busy_next;
    logic             done_reg, done_next;
    logic [RW:0]      trial;
    logic             ge;

    // trial = partial remainder shifted left with next dividend bit
    assign trial = {rem_reg, quo_reg[WIDTH-1]};
    assign ge    = (trial >= {1'b0, divisor});

    always_comb begin
        quo_next  = quo_reg;
        rem_next  = rem_reg;
        cnt_next  = cnt_reg;
        busy_next = busy_reg;
        done_next = 1'b0;
        if (start) begin
            quo_next  = dividend;
            rem_next  = '0;
            cnt_next  = CNT_W'(WIDTH - 1);
            busy_next = 1'b1;
        end else if (busy_reg) begin
            quo_next = {quo_reg[WIDTH-2:0], ge};
            rem_next = ge ? RW'(trial - {1'b0, divisor}) : trial[RW-1:0];
            cnt_next = cnt_reg - CNT_W'(1);
            if (cnt_reg == '0) begin
                busy_next = 1'b0;
                done_next = 1'b1;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
        end else begin
            busy_reg <= busy_next;
            done_reg <= done_next;
        end
    end

    always_ff @(posedge aclk) begin
        quo_reg <= quo_next;
        rem_reg <= rem_next;
        cnt_reg <= cnt_next;
    end

    assign quotient   = quo_reg;
    assign remainder  = rem_reg;
    assign stat.busy  = busy_reg;
    assign stat.done  = done_reg;

endmodule

// ----- dv/halton_radical_inverse_checker.sv -----
// Checker for halton_radical_inverse: predicts each request's fraction and compares results.
`timescale 1ns / 100ps

module halton_radical_inverse_checker (
    input  logic        aclk,
    input  logic        aresetn,
    input  logic        s_tvalid,
    input  logic        s_tready,
    input  logic [47:0] s_tdata,     // [31:0] sample_index, [47:32] radix
    input  logic        m_tvalid,
    input  logic        m_tready,
    input  logic [31:0] m_tdata,     // [31:0] fraction
    input  logic [0:0]  m_tuser,     // [0] bad_base
    output int unsigned fail_count,
    output int unsigned outstanding
);

    typedef struct packed {
        logic [hri_pkg::FRAC_W-1:0] fraction;
        logic                       bad_base;
    } inverse_t;

    inverse_t    expected_inverses[$];
    inverse_t    got;
    inverse_t    want;
    int unsigned errors = 0;

    // Digits of the index, least significant first, mirrored about the point.
    // The weight starts at floor(2^32 / radix) and is divided again per digit.
    function automatic inverse_t radical_inverse_q32(
        logic [hri_pkg::SAMPLE_W-1:0] index,
        logic [hri_pkg::RADIX_W-1:0]  radix);
        logic [63:0]                rest;
        logic [63:0]                weight;
        logic [63:0]                digit;
        logic [hri_pkg::FRAC_W-1:0] acc;
        inverse_t                   res;
        if (radix < hri_pkg::RADIX_MIN) begin
            res.fraction = '0;
            res.bad_base = 1'b1;
            return res;
        end
        rest   = 64'(index);
        weight = 64'h1_0000_0000;
        acc    = '0;
        while (rest != 0) begin
            digit  = rest % 64'(radix);
            weight = weight / 64'(radix);
            acc    = acc + hri_pkg::FRAC_W'(weight * digit);
            rest   = rest / 64'(radix);
        end
        res.fraction = acc;
        res.bad_base = 1'b0;
        return res;
    endfunction

    always @(posedge aclk) begin
        if (aresetn) begin
            // results first: a request accepted on this edge cannot be answered yet
            if (m_tvalid && m_tready) begin
                got.fraction = m_tdata;
                got.bad_base = m_tuser[0];
                if (expected_inverses.size() == 0) begin
                    $display("%0t: unexpected result, fraction %h bad_base %b",
                             $time, got.fraction, got.bad_base);
                    errors++;
                end else begin
                    want = expected_inverses.pop_front();
                    if (want.fraction !== got.fraction) begin
                        $display("%0t: fraction mismatch, expected %h, actual %h",
                                 $time, want.fraction, got.fraction);
                        errors++;
                    end
                    if (want.bad_base !== got.bad_base) begin
                        $display("%0t: bad_base mismatch, expected %b, actual %b",
                                 $time, want.bad_base, got.bad_base);
                        errors++;
                    end
                end
            end
            if (s_tvalid && s_tready) begin
                expected_inverses.insert(expected_inverses.size(),
                    radical_inverse_q32(s_tdata[hri_pkg::SAMPLE_W-1:0],
                                        s_tdata[hri_pkg::SAMPLE_W +: hri_pkg::RADIX_W]));
            end
        end
        outstanding <= expected_inverses.size();
        fail_count  <= errors;
    end

endmodule

// ----- dv/halton_radical_inverse_tb.sv -----
// Testbench top for halton_radical_inverse: request stimulus, result backpressure, verdict.
`timescale 1ns / 100ps

module halton_radical_inverse_tb;

    // Random requests per idling phase; four phases make about 1900 in all.
    localparam int PHASE_REQUESTS = 470;

    logic        aclk;
    logic        aresetn  = 1'b0;
    logic        s_tvalid = 1'b0;
    logic        s_tready;
    logic [47:0] s_tdata  = '0;    // [31:0] sample_index, [47:32] radix
    logic        m_tvalid;
    logic        m_tready = 1'b0;
    logic [31:0] m_tdata;          // [31:0] fraction
    logic [0:0]  m_tuser;          // [0] bad_base

    int unsigned fail_count;
    int unsigned outstanding;

    // Idling knobs, changed only between phases (percent of cycles).
    int sender_idle_pct    = 0;
    int receiver_stall_pct = 0;

    initial begin
        aclk = 1'b0;
        forever #1 aclk = ~aclk;
    end

    halton_radical_inverse u_top (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_tdata  (s_tdata),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata),
        .m_tuser  (m_tuser)
    );

    halton_radical_inverse_checker u_checker (
        .aclk        (aclk),
        .aresetn     (aresetn),
        .s_tvalid    (s_tvalid),
        .s_tready    (s_tready),
        .s_tdata     (s_tdata),
        .m_tvalid    (m_tvalid),
        .m_tready    (m_tready),
        .m_tdata     (m_tdata),
        .m_tuser     (m_tuser),
        .fail_count  (fail_count),
        .outstanding (outstanding)
    );

    // Result side backpressure: one coin per cycle at the phase's stall rate.
    always @(posedge aclk) begin
        if (!aresetn) begin
            m_tready <= 1'b0;
        end else begin
            m_tready <= ($urandom_range(99) >= receiver_stall_pct);
        end
    end

    // Offer one request and hold it until the handshake. An optional idle
    // stretch comes first; valid only drops when the task then waits on the clock
    // before raising it again, so tvalid never sees two updates in one step.
    task automatic send_request(input logic [hri_pkg::SAMPLE_W-1:0] index,
                                input logic [hri_pkg::RADIX_W-1:0]  radix);
        if (sender_idle_pct > 0 && $urandom_range(99) < sender_idle_pct) begin
            s_tvalid <= 1'b0;
            @(posedge aclk);
            while ($urandom_range(99) < sender_idle_pct) @(posedge aclk);
        end
        s_tvalid <= 1'b1;
        s_tdata  <= {radix, index};
        @(posedge aclk);
        while (!s_tready) @(posedge aclk);
    endtask

    // Sender goes quiet until every predicted result has been seen.
    task automatic drain_results();
        s_tvalid <= 1'b0;
        @(posedge aclk);
        while (outstanding != 0) @(posedge aclk);
    endtask

    // Random requests. Cost grows with the digit count, so small radixes
    // (up to 32 digits each) are kept to a small share, and
    // many indexes are shortened to a random bit length.
    task automatic send_random_requests(input int count);
        logic [hri_pkg::SAMPLE_W-1:0] index;
        logic [hri_pkg::RADIX_W-1:0]  radix;
        int                           pick;
        for (int n = 0; n < count; n++) begin
            pick  = $urandom_range(99);
            index = $urandom();
            if ($urandom_range(1) == 0) index = index >> $urandom_range(31);
            if (pick < 4) begin
                radix = hri_pkg::RADIX_W'($urandom_range(1));           // bad base
            end else if (pick < 14) begin
                radix = hri_pkg::RADIX_W'($urandom_range(15, 2));
            end else if (pick < 38) begin
                radix = hri_pkg::RADIX_W'($urandom_range(255, 16));
            end else begin
                radix = hri_pkg::RADIX_W'($urandom_range(65535, 256));
            end
            send_request(index, radix);
        end
    endtask

    initial begin
        repeat (2) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);

        // Directed: bad bases, index zero, field extremes, weight running
        // out to zero before the index does, full 32-digit radix 2.
        send_request(32'h0000_0000, 16'd2);
        send_request(32'h0000_0000, 16'd0);
        send_request(32'h0000_0005, 16'd1);
        send_request(32'hFFFF_FFFF, 16'd0);
        send_request(32'hFFFF_FFFF, 16'd1);
        send_request(32'h0000_0000, 16'hFFFF);
        send_request(32'h0000_0001, 16'd2);
        send_request(32'h0000_0001, 16'd3);
        send_request(32'h0000_0002, 16'd3);
        send_request(32'h0000_0008, 16'd2);
        send_request(32'h8000_0000, 16'd2);
        send_request(32'hFFFF_FFFF, 16'd2);
        send_request(32'hFFFF_FFFF, 16'd3);
        send_request(32'hFFFF_FFFF, 16'd10);
        send_request(32'h0000_0001, 16'hFFFF);
        send_request(32'h0000_FFFE, 16'hFFFF);
        send_request(32'h0000_FFFF, 16'hFFFF);
        send_request(32'hFFFF_FFFF, 16'hFFFF);   // third weight is zero
        send_request(32'hFFFF_FFFF, 16'd40000);  // third weight is zero
        send_request(32'hFFFF_FFFF, 16'hFFFE);
        send_request(32'hAAAA_5555, 16'h5555);
        send_request(32'h5555_AAAA, 16'hAAAA);
        drain_results();

        // Phase 1: both sides always ready.
        send_random_requests(PHASE_REQUESTS);
        drain_results();

        // Phase 2: sender idles often.
        sender_idle_pct    = 58;
        receiver_stall_pct = 0;
        send_random_requests(PHASE_REQUESTS);
        drain_results();

        // Phase 3: receiver stalls often.
        sender_idle_pct    = 0;
        receiver_stall_pct = 58;
        send_random_requests(PHASE_REQUESTS);
        drain_results();

        // Phase 4: both sides idle some of the time.
        sender_idle_pct    = 31;
        receiver_stall_pct = 31;
        send_random_requests(PHASE_REQUESTS);
        drain_results();

        // Result is registered after the last digit; allow slack.
        repeat (10) @(posedge aclk);
        if (fail_count == 0) begin
            $display("halton_radical_inverse_tb: done, clean");
        end else begin
            $display("halton_radical_inverse_tb: done, errors");
        end
        $finish;
    end

    // Hang guard: every request at its worst several times over.
    initial begin
        #40_000_000;
        $display("halton_radical_inverse_tb: done, errors");
        $finish;
    end

endmodule

// ----- halton_radical_inverse.f -----
+incdir+rtl
rtl/hri_pkg.sv
rtl/hri_div.sv
rtl/halton_radical_inverse.sv
dv/halton_radical_inverse_checker.sv
dv/halton_radical_inverse_tb.sv
